// File: sv/assert_macros.svh
// Assertion helpers shared by the block's modules.
// Both expect signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SMVP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define SMVP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/smvp_pkg.sv
package smvp_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int PROD_W = 2 * VAL_W;
   localparam int FRAC_W = 16;
   localparam int ACC_W = 48;
   localparam int ROW_W = 16;
   localparam int CFG_W = 11;

   localparam logic [CFG_W-1:0] COLS_RESET = 11'd1024;

   // Op codes carried on req_tuser; the fourth code means nothing.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_NONZERO = 2'd1;
   localparam logic [1:0] OP_EMPTY = 2'd2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic       last;
      logic       col_ok;
   } stage_ctrl_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_number;
      logic signed [ACC_W-1:0] row_sum;
      logic                    column_error;
   } result_type;

endpackage

// File: sv/smvp_ram.sv
module smvp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the read word while the pipeline stalls
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/smvp_acc.sv
`include "assert_macros.svh"

module smvp_acc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  smvp_pkg::stage_ctrl_type          ctrl,
   input  logic signed [smvp_pkg::PROD_W-1:0] product,
   output logic                              emit,
   output smvp_pkg::result_type              result
);

   logic signed [smvp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [smvp_pkg::ROW_W-1:0]        row_counter_ff, row_counter_in;
   logic                              row_error_ff, row_error_in;

   logic signed [smvp_pkg::ACC_W-1:0] term;
   logic signed [smvp_pkg::ACC_W:0]   wide_sum;
   logic signed [smvp_pkg::ACC_W-1:0] sat_sum;
   logic signed [smvp_pkg::ACC_W-1:0] acc_step;
   logic                              err_step;

   // drop the fraction bits: arithmetic shift rounds toward minus infinity
   assign term = $signed(product[smvp_pkg::PROD_W-1:smvp_pkg::FRAC_W]);
   assign wide_sum = {acc_ff[smvp_pkg::ACC_W-1], acc_ff} + {term[smvp_pkg::ACC_W-1], term};

   always_comb begin
      if (wide_sum[smvp_pkg::ACC_W] != wide_sum[smvp_pkg::ACC_W-1]) begin
         sat_sum = wide_sum[smvp_pkg::ACC_W] ? smvp_pkg::ACC_MIN : smvp_pkg::ACC_MAX;
      end else begin
         sat_sum = wide_sum[smvp_pkg::ACC_W-1:0];
      end
   end

   // an out-of-range column adds nothing and flags the row
   assign acc_step = ctrl.col_ok ? sat_sum : acc_ff;
   assign err_step = row_error_ff | ~ctrl.col_ok;

   always_comb begin
      acc_in = acc_ff;
      row_counter_in = row_counter_ff;
      row_error_in = row_error_ff;
      emit = 1'b0;
      result.row_number = row_counter_ff;
      result.row_sum = '0;
      result.column_error = 1'b0;
      if (ctrl.valid) begin
         case (ctrl.op)
            smvp_pkg::OP_LOAD: begin
               acc_in = '0;
               row_counter_in = '0;
               row_error_in = 1'b0;
            end
            smvp_pkg::OP_NONZERO: begin
               if (ctrl.last) begin
                  emit = 1'b1;
                  result.row_sum = acc_step;
                  result.column_error = err_step;
                  acc_in = '0;
                  row_error_in = 1'b0;
                  row_counter_in = row_counter_ff + 1'b1;
               end else begin
                  acc_in = acc_step;
                  row_error_in = err_step;
               end
            end
            smvp_pkg::OP_EMPTY: begin
               emit = 1'b1;
               row_counter_in = row_counter_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         row_counter_ff <= '0;
         row_error_ff <= 1'b0;
      end else if (advance) begin
         acc_ff <= acc_in;
         row_counter_ff <= row_counter_in;
         row_error_ff <= row_error_in;
      end
   end

   `SMVP_ASSERT_NEXT(a_load_clears, advance && ctrl.valid && ctrl.op == smvp_pkg::OP_LOAD, acc_ff == '0 && row_counter_ff == '0 && !row_error_ff, "load did not clear the row state")
   `SMVP_ASSERT_NEXT(a_close_clears, advance && ctrl.valid && ctrl.op == smvp_pkg::OP_NONZERO && ctrl.last, acc_ff == '0 && !row_error_ff, "row close left accumulator or error set")

endmodule

// File: sv/sparse_matrix_vector_product.sv
// CSR sparse matrix times dense vector in Q16.16. Load beats (tuser = 0) write
// one x entry into an on-chip vector RAM and restart the row count; nonzero
// beats (tuser = 1) multiply their value by x[column] and add the product,
// truncated to Q32.16, into a 48-bit saturating accumulator; tlast on a
// nonzero closes the row and sends {row number, sum, error}; an empty-row
// beat (tuser = 2) sends a zero sum at once; tuser = 3 is dropped. Columns at
// or past cols_in_use (capped at MAX_COLS) add nothing and set the row's error
// flag. The block takes one beat per clock unless stalled; the pipeline is RAM
// read, 32x32 multiply, accumulate and the output register. The accumulate
// stage folds one product per cycle into its own register, so back-to-back
// nonzeros of one row never wait. The input stalls only when a result is ready
// to leave the accumulator and the previous one still sits unclaimed in the
// output register. Vector entries must be loaded before any nonzero reads them;
// the user must write csr_wdata only while idle; the block does not enforce it.
`include "assert_macros.svh"

module sparse_matrix_vector_product #(
   parameter int MAX_COLS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // index [9:0], value [41:10], zero [47:42]
   input  logic [1:0]  req_tuser,  // op [1:0]
   input  logic        req_tlast,  // last_in_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // row_number [15:0], row_sum [63:16]
   output logic        rsp_tuser,  // column_error
   input  logic        csr_we,
   input  logic [10:0] csr_wdata   // cols_in_use
);

   localparam int ADDR_W = $clog2(MAX_COLS);
   localparam int LIM_W = 17;
   localparam logic [LIM_W-1:0] MAX_COLS_L = LIM_W'(MAX_COLS);

   logic [smvp_pkg::CFG_W-1:0] cols_ff;

   logic                              accept;
   logic                              advance;
   logic                              stall;
   logic [1:0]                        in_op;
   logic [smvp_pkg::IDX_W-1:0]        in_index;
   logic signed [smvp_pkg::VAL_W-1:0] in_value;
   logic [LIM_W-1:0]                  in_index_ext;
   logic [LIM_W-1:0]                  limit;

   smvp_pkg::stage_ctrl_type          s1_ctrl_ff, s1_ctrl_in;
   logic signed [smvp_pkg::VAL_W-1:0] s1_value_ff;
   smvp_pkg::stage_ctrl_type          s2_ctrl_ff;
   logic signed [smvp_pkg::PROD_W-1:0] s2_product_ff, s2_product_in;

   logic [smvp_pkg::VAL_W-1:0]        ram_rd_data;
   logic signed [smvp_pkg::VAL_W-1:0] x_entry;
   logic                              ram_wr_en;
   logic [ADDR_W-1:0]                 ram_addr;

   logic                 acc_emit;
   smvp_pkg::result_type acc_result;

   logic                 rsp_valid_ff, rsp_valid_in;
   smvp_pkg::result_type rsp_result_ff;

   // unpack the request beat
   assign in_op = req_tuser;
   assign in_index = req_tdata[9:0];
   assign in_value = $signed(req_tdata[41:10]);
   assign in_index_ext = LIM_W'(in_index);

   // column limit is the smaller of cols_in_use and the RAM depth
   assign limit = (LIM_W'(cols_ff) < MAX_COLS_L) ? LIM_W'(cols_ff) : MAX_COLS_L;

   // hold everything only when a result must leave and the output is still full
   assign stall = rsp_valid_ff && !rsp_tready && acc_emit;
   assign advance = !stall;
   assign req_tready = advance;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= smvp_pkg::COLS_RESET;
      end else if (csr_we) begin
         cols_ff <= csr_wdata;
      end
   end

   // stage 0: write loads straight into the RAM, issue reads for the rest
   assign ram_wr_en = accept && in_op == smvp_pkg::OP_LOAD && in_index_ext < MAX_COLS_L;
   assign ram_addr = ADDR_W'(in_index);

   smvp_ram #(
      .WIDTH (smvp_pkg::VAL_W),
      .DEPTH (MAX_COLS)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_tdata[41:10]),
      .rd_en   (advance),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_ctrl_in.valid = accept && (in_op == smvp_pkg::OP_LOAD ||
                                    in_op == smvp_pkg::OP_NONZERO ||
                                    in_op == smvp_pkg::OP_EMPTY);
      s1_ctrl_in.op = in_op;
      s1_ctrl_in.last = req_tlast;
      s1_ctrl_in.col_ok = in_index_ext < limit;
   end

   // stage 1: multiply by the x entry the RAM just returned
   assign x_entry = $signed(ram_rd_data);
   assign s2_product_in = s1_value_ff * x_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
         s2_ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_value_ff <= in_value;
         s2_product_ff <= s2_product_in;
      end
   end

   // stage 2: accumulate, saturate and close rows
   smvp_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctrl    (s2_ctrl_ff),
      .product (s2_product_ff),
      .emit    (acc_emit),
      .result  (acc_result)
   );

   // output register: load a new result, drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && acc_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && acc_emit) begin
         rsp_result_ff <= acc_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_result_ff.row_sum, rsp_result_ff.row_number};
   assign rsp_tuser = rsp_result_ff.column_error;

   `SMVP_ASSERT(a_stall_cause, !req_tready |-> rsp_valid_ff && !rsp_tready && acc_emit, "input stalled without a blocked result")
   `SMVP_ASSERT(a_no_overwrite, advance && acc_emit && rsp_valid_ff |-> rsp_tready, "pending result overwritten")
   `SMVP_ASSERT_NEXT(a_hold_pipe, stall && s1_ctrl_ff.valid, $stable(s1_ctrl_ff) && $stable(s1_value_ff), "stage 1 moved during a stall")

endmodule
